FILE: hdl/date_string_validator_macros.svh
// Assertion macros for the date string validator.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DATE_STRING_VALIDATOR_MACROS_SVH
`define DATE_STRING_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define DSV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define DSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define DSV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DSV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/dsv_pkg.sv
// Shared types and constants for the date string validator.
// No dependencies; used by dsv_date_check and date_string_validator.
package dsv_pkg;

  localparam int MAX_LEN_SINGLE = 10;
  localparam int MAX_LEN_RANGE  = 18;
  localparam int DIGIT_DEPTH    = (MAX_LEN_RANGE > MAX_LEN_SINGLE) ?
                                  MAX_LEN_RANGE : MAX_LEN_SINGLE;
  localparam int CNT_W          = $clog2(DIGIT_DEPTH + 1);
  localparam int IDX_W          = $clog2(DIGIT_DEPTH);
  localparam int DATE_DIGITS    = 8;

  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] CE_NONE      = 3'd0;
  localparam logic [2:0] CE_PERIOD    = 3'd1;
  localparam logic [2:0] CE_NO_RANGE  = 3'd2;
  localparam logic [2:0] CE_HYPHEN2   = 3'd3;
  localparam logic [2:0] CE_SPACE     = 3'd4;
  localparam logic [2:0] CE_NUL       = 3'd5;
  localparam logic [2:0] CE_CRLF      = 3'd6;
  localparam logic [2:0] CE_OTHER     = 3'd7;

  localparam logic [1:0] DE_NONE     = 2'd0;
  localparam logic [1:0] DE_CALENDAR = 2'd1;
  localparam logic [1:0] DE_COUNT    = 2'd2;

  typedef logic [3:0] digit_t;
  typedef digit_t date_digits_t [DATE_DIGITS];

  typedef struct packed {
    logic       kind;
    logic [7:0] character;
  } in_word_t;

  typedef struct packed {
    logic       valid_res;
    logic       length_exceeded;
    logic [2:0] char_error;
    logic [1:0] start_date_error;
    logic [1:0] end_date_error;
    logic       order_error;
    logic       old_style_warning;
  } out_word_t;

endpackage

FILE: hdl/dsv_date_check.sv
// Verdict on one stored date: Gregorian calendar check on eight digits,
// digit count rule otherwise. Depends on dsv_pkg.
module dsv_date_check (
  input  dsv_pkg::date_digits_t    digits,
  input  logic [dsv_pkg::CNT_W-1:0] count,
  input  logic                     old_style,
  output logic [1:0]               verdict
);

  logic [6:0] month;
  logic [6:0] day;
  logic [6:0] dim;
  logic [1:0] lo_mod4;
  logic [1:0] hi_mod4;
  logic       lo_zero;
  logic       leap;
  logic       cal_ok;

  always_comb begin
    month = 7'(digits[4]) * 7'd10 + 7'(digits[5]);
    day   = 7'(digits[6]) * 7'd10 + 7'(digits[7]);
    // (10*t + u) mod 4 == (2*t + u) mod 4
    lo_mod4 = {digits[2][0], 1'b0} + digits[3][1:0];
    hi_mod4 = {digits[0][0], 1'b0} + digits[1][1:0];
    lo_zero = (digits[2] == 4'd0) && (digits[3] == 4'd0);
    leap    = (lo_mod4 == 2'd0 && !lo_zero) || (lo_zero && hi_mod4 == 2'd0);
    case (month)
      7'd2:                        dim = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:     dim = 7'd30;
      default:                     dim = 7'd31;
    endcase
    cal_ok = (month >= 7'd1) && (month <= 7'd12) && (day >= 7'd1) && (day <= dim);

    if (count == dsv_pkg::CNT_W'(dsv_pkg::DATE_DIGITS)) begin
      verdict = cal_ok ? dsv_pkg::DE_NONE : dsv_pkg::DE_CALENDAR;
    end else if (count == '0 || old_style) begin
      verdict = dsv_pkg::DE_NONE;
    end else begin
      verdict = dsv_pkg::DE_COUNT;
    end
  end

endmodule

FILE: hdl/date_string_validator.sv
// Date string validator: per-character checks, digit capture and end-of-value verdict.
// Depends on dsv_pkg, dsv_date_check and date_string_validator_macros.svh.
// The verdict is registered into the result register, or into the skid slot while the result register is held.
// Throughput: one word per cycle; input stalls only while both result slots are full.
// Reset (rst, synchronous) clears the register, the value state and both result slots;
// the digit stores keep their contents and are read only below their counts.
`include "date_string_validator_macros.svh"

module date_string_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  dsv_pkg::in_word_t   item_word,
  output logic                res_valid,
  input  logic                res_stall,
  output dsv_pkg::out_word_t  res_word
);

  typedef enum logic [1:0] {CMP_EQ, CMP_GT, CMP_LT} cmp_t;

  localparam int CNT_W = dsv_pkg::CNT_W;
  localparam int IDX_W = dsv_pkg::IDX_W;

  logic             ranges_allowed;
  logic [CNT_W-1:0] char_position, char_position_next;
  logic             truncated, truncated_next;
  logic             range_seen, range_seen_next;
  logic [CNT_W-1:0] start_count, start_count_next;
  logic [CNT_W-1:0] end_count, end_count_next;
  logic             start_old_style, start_old_style_next;
  logic             end_old_style, end_old_style_next;
  logic             pending_space, pending_space_next;
  logic [2:0]       stopped_error, stopped_error_next;
  cmp_t             cmp, cmp_next;

  dsv_pkg::digit_t  start_digits [dsv_pkg::DIGIT_DEPTH];
  dsv_pkg::digit_t  end_digits [dsv_pkg::DATE_DIGITS];

  logic             skid_valid;
  dsv_pkg::out_word_t skid_word;

  logic             item_acc;
  logic             drain;
  logic [CNT_W-1:0] maxlen;
  logic [7:0]       ch;
  dsv_pkg::digit_t  dig;
  logic             wr_start, wr_end;
  logic             res_new;
  dsv_pkg::out_word_t res_calc;
  dsv_pkg::date_digits_t start_head;
  logic [1:0]       se_raw, ee_raw;
  logic [2:0]       ce;
  logic             chk;
  logic             later;
  logic [1:0]       se, ee;
  logic             oe, ow;

  assign item_stall = skid_valid;
  assign item_acc   = item_valid && !item_stall;
  assign drain      = res_valid && !res_stall;
  assign ch         = item_word.character;
  assign dig        = ch[3:0];
  assign maxlen     = ranges_allowed ? CNT_W'(dsv_pkg::MAX_LEN_RANGE) :
                                       CNT_W'(dsv_pkg::MAX_LEN_SINGLE);

  always_comb begin
    for (int i = 0; i < dsv_pkg::DATE_DIGITS; i++) begin
      start_head[i] = start_digits[i];
    end
  end

  dsv_date_check u_start_check (
    .digits   (start_head),
    .count    (start_count),
    .old_style(start_old_style),
    .verdict  (se_raw)
  );

  dsv_date_check u_end_check (
    .digits   (end_digits),
    .count    (end_count),
    .old_style(end_old_style),
    .verdict  (ee_raw)
  );

  // end-of-value verdict from the stored state
  always_comb begin
    ce = stopped_error;
    if (ce == dsv_pkg::CE_NONE && pending_space && char_position[0]) begin
      ce = dsv_pkg::CE_SPACE;
    end
    chk   = (ce == dsv_pkg::CE_NONE) && (char_position != '0);
    se    = chk ? se_raw : dsv_pkg::DE_NONE;
    ee    = (chk && range_seen) ? ee_raw : dsv_pkg::DE_NONE;
    later = (cmp == CMP_GT) || (cmp == CMP_EQ && start_count > end_count);
    oe    = chk && range_seen && !truncated && se == dsv_pkg::DE_NONE &&
            ee == dsv_pkg::DE_NONE && end_count != '0 && later;
    ow    = chk && (start_old_style || end_old_style);
    res_calc.valid_res         = !truncated && ce == dsv_pkg::CE_NONE &&
                                 se == dsv_pkg::DE_NONE && ee == dsv_pkg::DE_NONE && !oe;
    res_calc.length_exceeded   = truncated;
    res_calc.char_error        = ce;
    res_calc.start_date_error  = se;
    res_calc.end_date_error    = ee;
    res_calc.order_error       = oe;
    res_calc.old_style_warning = ow;
  end

  // per-word state update
  always_comb begin
    char_position_next   = char_position;
    truncated_next       = truncated;
    range_seen_next      = range_seen;
    start_count_next     = start_count;
    end_count_next       = end_count;
    start_old_style_next = start_old_style;
    end_old_style_next   = end_old_style;
    pending_space_next   = pending_space;
    stopped_error_next   = stopped_error;
    cmp_next             = cmp;
    wr_start             = 1'b0;
    wr_end               = 1'b0;
    res_new              = 1'b0;

    if (item_acc) begin
      if (item_word.kind == dsv_pkg::KIND_END) begin
        res_new              = 1'b1;
        char_position_next   = '0;
        truncated_next       = 1'b0;
        range_seen_next      = 1'b0;
        start_count_next     = '0;
        end_count_next       = '0;
        start_old_style_next = 1'b0;
        end_old_style_next   = 1'b0;
        pending_space_next   = 1'b0;
        stopped_error_next   = dsv_pkg::CE_NONE;
        cmp_next             = CMP_EQ;
      end else if (char_position >= maxlen) begin
        truncated_next = 1'b1;
      end else begin
        char_position_next = char_position + 1'b1;
        if (stopped_error != dsv_pkg::CE_NONE) begin
          // checking has stopped; only the length still counts
        end else if (pending_space) begin
          stopped_error_next = dsv_pkg::CE_SPACE;
        end else if (ch >= dsv_pkg::CH_ZERO && ch <= dsv_pkg::CH_NINE) begin
          if (range_seen) begin
            if (end_count < CNT_W'(dsv_pkg::DIGIT_DEPTH)) begin
              wr_end         = end_count < CNT_W'(dsv_pkg::DATE_DIGITS);
              end_count_next = end_count + 1'b1;
              // running lexicographic compare against the start digit at this index
              if (cmp == CMP_EQ && end_count < start_count &&
                  start_digits[end_count[IDX_W-1:0]] != dig) begin
                cmp_next = (start_digits[end_count[IDX_W-1:0]] > dig) ? CMP_GT : CMP_LT;
              end
            end
          end else if (start_count < CNT_W'(dsv_pkg::DIGIT_DEPTH)) begin
            wr_start         = 1'b1;
            start_count_next = start_count + 1'b1;
          end
        end else if (ch == dsv_pkg::CH_PERIOD) begin
          if (range_seen) begin
            if (end_count == '0) stopped_error_next = dsv_pkg::CE_PERIOD;
            else end_old_style_next = 1'b1;
          end else begin
            if (start_count == '0) stopped_error_next = dsv_pkg::CE_PERIOD;
            else start_old_style_next = 1'b1;
          end
        end else if (ch == dsv_pkg::CH_HYPHEN) begin
          if (!ranges_allowed) stopped_error_next = dsv_pkg::CE_NO_RANGE;
          else if (range_seen) stopped_error_next = dsv_pkg::CE_HYPHEN2;
          else range_seen_next = 1'b1;
        end else if (ch == dsv_pkg::CH_SPACE) begin
          pending_space_next = 1'b1;
        end else if (ch == dsv_pkg::CH_NUL) begin
          stopped_error_next = dsv_pkg::CE_NUL;
        end else if (ch == dsv_pkg::CH_LF || ch == dsv_pkg::CH_CR) begin
          stopped_error_next = dsv_pkg::CE_CRLF;
        end else begin
          stopped_error_next = dsv_pkg::CE_OTHER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ranges_allowed  <= 1'b0;
      char_position   <= '0;
      truncated       <= 1'b0;
      range_seen      <= 1'b0;
      start_count     <= '0;
      end_count       <= '0;
      start_old_style <= 1'b0;
      end_old_style   <= 1'b0;
      pending_space   <= 1'b0;
      stopped_error   <= dsv_pkg::CE_NONE;
      cmp             <= CMP_EQ;
    end else begin
      if (cfg_wr_en) ranges_allowed <= cfg_wr_data;
      char_position   <= char_position_next;
      truncated       <= truncated_next;
      range_seen      <= range_seen_next;
      start_count     <= start_count_next;
      end_count       <= end_count_next;
      start_old_style <= start_old_style_next;
      end_old_style   <= end_old_style_next;
      pending_space   <= pending_space_next;
      stopped_error   <= stopped_error_next;
      cmp             <= cmp_next;
    end
  end

  // digit stores, no reset
  always_ff @(posedge clk) begin
    if (wr_start) start_digits[start_count[IDX_W-1:0]] <= dig;
    if (wr_end) end_digits[end_count[$clog2(dsv_pkg::DATE_DIGITS)-1:0]] <= dig;
  end

  // result register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        res_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (res_new) begin
      if (!res_valid || drain) begin
        res_word  <= res_calc;
        res_valid <= 1'b1;
      end else begin
        skid_word  <= res_calc;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      res_valid <= 1'b0;
    end
  end

  `DSV_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, res_valid)
  `DSV_ASSERT_NEXT(a_end_clears, clk, rst, item_acc && item_word.kind == dsv_pkg::KIND_END,
    char_position == '0 && start_count == '0 && end_count == '0 && !range_seen)
  `DSV_ASSERT_IMPLIES(a_end_needs_range, clk, rst, end_count != '0, range_seen)
  `DSV_ASSERT_IMPLIES(a_verdict_flags, clk, rst, res_valid && res_word.valid_res,
    !res_word.length_exceeded && res_word.char_error == dsv_pkg::CE_NONE &&
    !res_word.order_error)

endmodule

FILE: dv/date_string_validator_tb.sv
// Self-checking testbench for date_string_validator: random-gap word driver,
// stalling result monitor and an in-bench predictor of the date verdicts.
// Depends on dsv_pkg and the date_string_validator RTL.
module date_string_validator_tb;

  typedef enum logic [1:0] {OP_WORD, OP_SYNC, OP_CFG, OP_HOLD} plan_code_t;

  typedef struct {
    plan_code_t        code;
    dsv_pkg::in_word_t word;
    int                gap;
    logic              arg;
  } plan_op_t;

  localparam int RANDOM_WORDS  = 650;
  localparam int PHASE_WORDS   = 160;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 8;
  localparam int MAX_GAP       = 18;
  localparam int DIGIT_SLOTS   = 32;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               item_valid;
  logic               item_stall;
  dsv_pkg::in_word_t  item_word;
  logic               res_valid;
  logic               res_stall;
  dsv_pkg::out_word_t res_word;

  date_string_validator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item_word   (item_word),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_word    (res_word)
  );

  // stimulus plan and expected verdicts
  plan_op_t           plan_q[$];
  dsv_pkg::out_word_t verdicts_due[$];
  logic [7:0]         spelled[$];
  int                 words_planned;
  bit                 tx_calm;
  logic               plan_ranges;

  // handshake bookkeeping between the edge processes
  bit          word_taken;
  bit          res_taken;
  int          quiet;
  int          gap_left;
  bit          gap_armed;
  int          settle;
  int          hold_token;
  int          hold_ack;
  int          hold_left;
  int          stall_left;
  bit          rx_calm;

  // predictor copy of the register and the per-value state
  logic        ranges_now;
  int          v_pos;
  logic        v_trunc;
  logic        v_range;
  logic [31:0][3:0] s_dig;
  logic [31:0][3:0] e_dig;
  int          s_cnt;
  int          e_cnt;
  logic        v_sold;
  logic        v_eold;
  logic        v_space;
  logic [2:0]  v_stop;

  // statistics
  int errors;
  int words_seen;
  int n_verdicts;
  int n_pass;
  int n_trunc;
  int n_chr;
  int n_date;
  int n_order;
  int n_old;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic calendar_fine(input logic [31:0][3:0] d);
    int yr, mo, dy, dim;
    logic leap;
    yr = int'(d[0]) * 1000 + int'(d[1]) * 100 + int'(d[2]) * 10 + int'(d[3]);
    mo = int'(d[4]) * 10 + int'(d[5]);
    dy = int'(d[6]) * 10 + int'(d[7]);
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (mo == 2) dim = leap ? 29 : 28;
    else if (mo == 4 || mo == 6 || mo == 9 || mo == 11) dim = 30;
    else dim = 31;
    return (mo >= 1) && (mo <= 12) && (dy >= 1) && (dy <= dim);
  endfunction

  function automatic logic [1:0] date_grade(input logic [31:0][3:0] d, input int cnt,
                                            input logic old);
    if (cnt == dsv_pkg::DATE_DIGITS)
      return calendar_fine(d) ? dsv_pkg::DE_NONE : dsv_pkg::DE_CALENDAR;
    if (cnt == 0 || old) return dsv_pkg::DE_NONE;
    return dsv_pkg::DE_COUNT;
  endfunction

  // digit strings compared as text: a is later than b
  function automatic logic runs_later(input logic [31:0][3:0] a, input int na,
                                      input logic [31:0][3:0] b, input int nb);
    int n;
    n = (na < nb) ? na : nb;
    for (int i = 0; i < n; i++)
      if (a[i] != b[i]) return a[i] > b[i];
    return na > nb;
  endfunction

  task automatic forget_value();
    v_pos = 0;
    v_trunc = 1'b0;
    v_range = 1'b0;
    s_dig = '0;
    e_dig = '0;
    s_cnt = 0;
    e_cnt = 0;
    v_sold = 1'b0;
    v_eold = 1'b0;
    v_space = 1'b0;
    v_stop = dsv_pkg::CE_NONE;
  endtask

  task automatic track_word(input dsv_pkg::in_word_t w);
    int lim;
    logic [7:0] c;
    logic [2:0] ce;
    logic [1:0] se, ee;
    logic oe, ow;
    dsv_pkg::out_word_t v;
    lim = ranges_now ? dsv_pkg::MAX_LEN_RANGE : dsv_pkg::MAX_LEN_SINGLE;
    c = w.character;
    if (w.kind == dsv_pkg::KIND_CHAR) begin
      if (v_pos >= lim) begin
        v_trunc = 1'b1;
      end else begin
        v_pos++;
        if (v_stop != dsv_pkg::CE_NONE) begin
        end else if (v_space) begin
          // space was not the last counted character
          v_stop = dsv_pkg::CE_SPACE;
        end else if (c >= dsv_pkg::CH_ZERO && c <= dsv_pkg::CH_NINE) begin
          if (v_range) begin
            if (e_cnt < DIGIT_SLOTS) begin
              e_dig[e_cnt] = 4'(c - dsv_pkg::CH_ZERO);
              e_cnt++;
            end
          end else begin
            if (s_cnt < DIGIT_SLOTS) begin
              s_dig[s_cnt] = 4'(c - dsv_pkg::CH_ZERO);
              s_cnt++;
            end
          end
        end else if (c == dsv_pkg::CH_PERIOD) begin
          if (v_range) begin
            if (e_cnt == 0) v_stop = dsv_pkg::CE_PERIOD;
            else v_eold = 1'b1;
          end else begin
            if (s_cnt == 0) v_stop = dsv_pkg::CE_PERIOD;
            else v_sold = 1'b1;
          end
        end else if (c == dsv_pkg::CH_HYPHEN) begin
          if (!ranges_now) v_stop = dsv_pkg::CE_NO_RANGE;
          else if (v_range) v_stop = dsv_pkg::CE_HYPHEN2;
          else v_range = 1'b1;
        end else if (c == dsv_pkg::CH_SPACE) begin
          v_space = 1'b1;
        end else if (c == dsv_pkg::CH_NUL) begin
          v_stop = dsv_pkg::CE_NUL;
        end else if (c == dsv_pkg::CH_LF || c == dsv_pkg::CH_CR) begin
          v_stop = dsv_pkg::CE_CRLF;
        end else begin
          v_stop = dsv_pkg::CE_OTHER;
        end
      end
    end else begin
      ce = v_stop;
      se = dsv_pkg::DE_NONE;
      ee = dsv_pkg::DE_NONE;
      oe = 1'b0;
      ow = 1'b0;
      if (ce == dsv_pkg::CE_NONE && v_space && (v_pos % 2 == 1)) ce = dsv_pkg::CE_SPACE;
      if (ce == dsv_pkg::CE_NONE && v_pos != 0) begin
        ow = v_sold || v_eold;
        se = date_grade(s_dig, s_cnt, v_sold);
        if (v_range) begin
          ee = date_grade(e_dig, e_cnt, v_eold);
          if (!v_trunc && se == dsv_pkg::DE_NONE && ee == dsv_pkg::DE_NONE && e_cnt > 0 &&
              runs_later(s_dig, s_cnt, e_dig, e_cnt))
            oe = 1'b1;
        end
      end
      v.valid_res = !v_trunc && ce == dsv_pkg::CE_NONE && se == dsv_pkg::DE_NONE &&
                    ee == dsv_pkg::DE_NONE && !oe;
      v.length_exceeded = v_trunc;
      v.char_error = ce;
      v.start_date_error = se;
      v.end_date_error = ee;
      v.order_error = oe;
      v.old_style_warning = ow;
      verdicts_due.push_back(v);
      forget_value();
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH verdict %0d %s: got %0d, expected %0d", n_verdicts, what, got, want);
    errors++;
  endtask

  task automatic check_verdict(input dsv_pkg::out_word_t got);
    dsv_pkg::out_word_t want;
    if (verdicts_due.size() == 0) begin
      flag_mismatch("verdict with nothing pending", int'(got), -1);
    end else begin
      want = verdicts_due.pop_front();
      if (got.valid_res !== want.valid_res)
        flag_mismatch("valid_res", got.valid_res, want.valid_res);
      if (got.length_exceeded !== want.length_exceeded)
        flag_mismatch("length_exceeded", got.length_exceeded, want.length_exceeded);
      if (got.char_error !== want.char_error)
        flag_mismatch("char_error", got.char_error, want.char_error);
      if (got.start_date_error !== want.start_date_error)
        flag_mismatch("start_date_error", got.start_date_error, want.start_date_error);
      if (got.end_date_error !== want.end_date_error)
        flag_mismatch("end_date_error", got.end_date_error, want.end_date_error);
      if (got.order_error !== want.order_error)
        flag_mismatch("order_error", got.order_error, want.order_error);
      if (got.old_style_warning !== want.old_style_warning)
        flag_mismatch("old_style_warning", got.old_style_warning, want.old_style_warning);
      n_pass += want.valid_res;
      n_trunc += want.length_exceeded;
      n_chr += (want.char_error != dsv_pkg::CE_NONE);
      n_date += (want.start_date_error != dsv_pkg::DE_NONE) ||
                (want.end_date_error != dsv_pkg::DE_NONE);
      n_order += want.order_error;
      n_old += want.old_style_warning;
    end
    n_verdicts++;
  endtask

  // ---------------------------------------------------------------- plan building

  task automatic push_op(input plan_code_t code, input logic arg);
    plan_op_t op;
    op.code = code;
    op.word = '0;
    op.gap = 0;
    op.arg = arg;
    plan_q.push_back(op);
  endtask

  task automatic push_cfg(input logic v);
    push_op(OP_SYNC, 1'b0);
    push_op(OP_CFG, v);
    plan_ranges = v;
  endtask

  function automatic int sender_gap(input bit rush);
    return (rush || tx_calm) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // turn the spelled characters plus an end marker into planned words
  task automatic emit_value(input bit rush);
    plan_op_t op;
    if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
    op.code = OP_WORD;
    op.arg = 1'b0;
    foreach (spelled[i]) begin
      op.word.kind = dsv_pkg::KIND_CHAR;
      op.word.character = spelled[i];
      op.gap = sender_gap(rush);
      plan_q.push_back(op);
    end
    op.word.kind = dsv_pkg::KIND_END;
    op.word.character = 8'($urandom_range(0, 255));
    op.gap = sender_gap(rush);
    plan_q.push_back(op);
    words_planned += spelled.size() + 1;
    spelled.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) spelled.push_back(s[i]);
  endtask

  task automatic value_of(input string s);
    add_text(s);
    emit_value(1'b0);
  endtask

  task automatic value_with(input string s, input logic [7:0] c);
    add_text(s);
    spelled.push_back(c);
    emit_value(1'b0);
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 9))
      0: return dsv_pkg::CH_PERIOD;
      1: return dsv_pkg::CH_HYPHEN;
      2: return dsv_pkg::CH_SPACE;
      3: return dsv_pkg::CH_NUL;
      4: return dsv_pkg::CH_LF;
      5: return dsv_pkg::CH_CR;
      6: return dsv_pkg::CH_ZERO - 8'd1;
      7: return dsv_pkg::CH_NINE + 8'd1;
      8: return dsv_pkg::CH_ZERO;
      default: return dsv_pkg::CH_NINE;
    endcase
  endfunction

  task automatic add_digits(input int n, input bit dots);
    for (int i = 0; i < n; i++)
      spelled.push_back((dots && $urandom_range(0, 4) == 0) ? dsv_pkg::CH_PERIOD :
                        dsv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // calendar-like date, biased toward month and leap-year boundaries
  task automatic add_date(input bit old_style);
    int yr, mo, dy;
    case ($urandom_range(0, 7))
      0: yr = 1900;
      1: yr = 2000;
      2: yr = 2100;
      3: yr = 4 * $urandom_range(0, 2499);
      4: yr = $urandom_range(0, 1) ? 0 : 9999;
      default: yr = $urandom_range(0, 9999);
    endcase
    mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 7))
      0: dy = $urandom_range(0, 1) ? 0 : 32;
      1: dy = 29;
      2: dy = 30;
      3: dy = 31;
      4: dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : 28;
      default: dy = $urandom_range(1, 28);
    endcase
    if (old_style) add_text($sformatf("%04d.%02d.%02d", yr, mo, dy));
    else add_text($sformatf("%04d%02d%02d", yr, mo, dy));
  endtask

  task automatic add_random_value(input logic span);
    int pick, n, at;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      add_date($urandom_range(0, 3) == 0);
      if (span) begin
        spelled.push_back(dsv_pkg::CH_HYPHEN);
        if ($urandom_range(0, 4) != 0) add_date($urandom_range(0, 5) == 0);
        else add_digits($urandom_range(0, 9), 1'b0);
      end
    end else if (pick < 75) begin
      add_digits($urandom_range(0, 10), 1'b1);
      if (span) begin
        spelled.push_back(dsv_pkg::CH_HYPHEN);
        add_digits($urandom_range(0, 9), 1'b1);
      end
    end else if (pick < 88) begin
      add_date(1'b0);
      if (span) begin
        spelled.push_back(dsv_pkg::CH_HYPHEN);
        add_date(1'b0);
      end
      at = $urandom_range(0, spelled.size() - 1);
      spelled[at] = pick_special();
    end else begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++)
        spelled.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_special());
    end
    // final pad to even length, sometimes a misplaced one
    if ($urandom_range(0, 7) == 0 && spelled.size() % 2 == 1)
      spelled.push_back(dsv_pkg::CH_SPACE);
    else if ($urandom_range(0, 15) == 0)
      spelled.push_back(dsv_pkg::CH_SPACE);
    if ($urandom_range(0, 9) == 0) add_digits($urandom_range(1, 5), 1'b0);
  endtask

  task automatic build_plan();
    int base, phase_base, ph;
    bit held;
    push_cfg(1'b0);
    value_of("");
    value_of("20240229");
    value_of("19000229");
    value_of("00000229");
    value_of("99991231");
    value_of("20231131");
    value_of("2023.11.30");
    value_of(".2023");
    value_of("1999.1");
    value_of("2023-0101");
    value_of("1999123 ");
    value_of("202301 ");
    value_of("1999 1231");
    value_with("2023", dsv_pkg::CH_NUL);
    value_with("2023", dsv_pkg::CH_LF);
    value_with("2023", dsv_pkg::CH_CR);
    value_of("2023/");
    value_with("2023", 8'hff);
    value_of("2023010112345");
    value_of("123456789 XY");
    push_cfg(1'b1);
    value_of("20230101-20231231");
    value_of("20231231-20230101");
    value_of("2023-");
    value_of("-20230101");
    value_of("2023-2024-");
    value_of("2023.01.01-2024");
    value_of("2023.0-2023.");
    value_of("20230101-20231231XY");
    value_of("20230101-2023123 ");

    base = words_planned;
    ph = 0;
    while (words_planned - base < RANDOM_WORDS) begin
      push_cfg((ph % 2 == 0) ? 1'b0 : 1'b1);
      ph++;
      phase_base = words_planned;
      held = 1'b0;
      while (words_planned - phase_base < PHASE_WORDS &&
             words_planned - base < RANDOM_WORDS) begin
        if (!held && words_planned - phase_base > 60) begin
          // receiver goes quiet while a burst keeps coming, filling the block
          push_op(OP_HOLD, 1'b0);
          for (int i = 0; i < 12; i++) begin
            if ($urandom_range(0, 2) != 0) add_date(1'b0);
            emit_value(1'b1);
          end
          held = 1'b1;
        end
        add_random_value(plan_ranges || $urandom_range(0, 9) == 0);
        emit_value(1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------- edge processes

  always @(negedge clk) begin : sender
    plan_op_t op;
    logic v_n, we_n, wd_n;
    dsv_pkg::in_word_t w_n;
    if (!rst) begin
      v_n = item_valid;
      w_n = item_word;
      we_n = 1'b0;
      wd_n = cfg_wr_data;
      if (word_taken) begin
        v_n = 1'b0;
        word_taken = 1'b0;
      end
      if (!v_n && plan_q.size() != 0) begin
        op = plan_q[0];
        case (op.code)
          OP_WORD: begin
            if (!gap_armed) begin
              gap_left = op.gap;
              gap_armed = 1'b1;
            end
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              v_n = 1'b1;
              w_n = op.word;
              gap_armed = 1'b0;
              void'(plan_q.pop_front());
            end
          end
          OP_SYNC: begin
            // hold off until every verdict is back, then let the pipe drain
            if (verdicts_due.size() != 0) settle = 0;
            else if (settle < SETTLE_CYCLES) settle++;
            else begin
              settle = 0;
              void'(plan_q.pop_front());
            end
          end
          OP_CFG: begin
            we_n = 1'b1;
            wd_n = op.arg;
            ranges_now = op.arg;
            void'(plan_q.pop_front());
          end
          OP_HOLD: begin
            hold_token <= hold_token + 1;
            void'(plan_q.pop_front());
          end
          default: ;
        endcase
      end
      item_valid <= v_n;
      item_word <= w_n;
      cfg_wr_en <= we_n;
      cfg_wr_data <= wd_n;
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (hold_token != hold_ack) begin
        hold_ack = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (res_taken) begin
        res_taken = 1'b0;
        if (n_verdicts % 32 == 0 && $urandom_range(0, 2) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (res_valid && stall_left != 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    if (!rst) begin
      if (res_valid && !res_stall) begin
        check_verdict(res_word);
        res_taken = 1'b1;
      end
      if (item_valid && !item_stall) begin
        track_word(item_word);
        word_taken = 1'b1;
        words_seen++;
      end
      if ((res_valid && !res_stall) || (item_valid && !item_stall)) quiet = 0;
      else quiet++;
    end
  end

  initial begin : main
    rst = 1'b1;
    item_valid = 1'b0;
    item_word = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    res_stall = 1'b0;
    ranges_now = 1'b0;
    plan_ranges = 1'b0;
    forget_value();
    stall_left = $urandom_range(0, MAX_GAP);
    build_plan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (quiet < QUIET_LIMIT &&
           !(plan_q.size() == 0 && !item_valid && verdicts_due.size() == 0))
      @(posedge clk);
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
               QUIET_LIMIT, verdicts_due.size());
      $display("date_string_validator verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      $display("covered %0d words, %0d verdicts: %0d clean, %0d over length, %0d char errors",
               words_seen, n_verdicts, n_pass, n_trunc, n_chr);
      $display("  %0d date errors, %0d order errors, %0d old style; %0d mismatches",
               n_date, n_order, n_old, errors);
      if (errors == 0) $display("date_string_validator verification clean");
      else $display("date_string_validator verification failed");
    end
    $finish;
  end

endmodule
